FILE: hw/rtl/lags_pkg.sv
// Shared types and constants for the lookahead goal selector.
`timescale 1ns / 1ps

package lags_pkg;

	localparam int unsigned LOOK_BITS = 24;
	localparam int unsigned SLOT_BITS = 10;

	localparam logic [LOOK_BITS-1:0]   LOOK_RESET    = 24'd1280;
	localparam logic [2*LOOK_BITS-1:0] LOOK_SQ_RESET = 48'd1638400;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_POSE = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RD   = 6'b000010,
		ST_DIFF = 6'b000100,
		ST_MUL  = 6'b001000,
		ST_CMP  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic start;
		logic rd;
		logic diff;
		logic mul;
		logic step;
		logic commit;
	} cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic path_empty;
		logic more;
		logic out_busy;
	} sts_t;

endpackage

FILE: hw/rtl/lags_wpmem.sv
// Waypoint memory with one write port and one registered read port.
`timescale 1ns / 1ps

module lags_wpmem #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/lags_ctrl.sv
// Controller state machine that sequences loads and the waypoint walk.
`timescale 1ns / 1ps

module lags_ctrl
	import lags_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic req_type,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_LOAD) begin
						cmd.load = 1'b1;
					end else if (!sts.path_empty) begin
						cmd.start = 1'b1;
						state_d   = ST_RD;
					end
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (sts.more) begin
					cmd.step = 1'b1;
					state_d  = ST_RD;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				// Wait until the output register is free for the new word.
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hw/rtl/lags_dp.sv
// Datapath: path counters, goal index, distance arithmetic and output register.
`timescale 1ns / 1ps

module lags_dp
	import lags_pkg::*;
#(
	parameter int unsigned MAX_WAYPOINTS = 1024,
	parameter int unsigned COORD_BITS    = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	output sts_t                         sts,
	input  logic                         cfg_valid,
	input  logic [LOOK_BITS-1:0]         cfg_data,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic                         path_last,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS-1:0] goal_x,
	output logic signed [COORD_BITS-1:0] goal_y,
	output logic [SLOT_BITS-1:0]         goal_slot
);

	localparam int unsigned CW = COORD_BITS;
	localparam int unsigned IW = $clog2(MAX_WAYPOINTS);
	localparam int unsigned LW = $clog2(MAX_WAYPOINTS + 1);
	localparam int unsigned SQ_W = 2 * CW + 1;
	localparam int unsigned LSQ_W = 2 * LOOK_BITS;
	localparam int unsigned DW = (SQ_W > LSQ_W) ? SQ_W : LSQ_W;

	logic [LW-1:0]        fill_q, len_q, fill_nxt, len_m1;
	logic                 full;
	logic [IW-1:0]        idx_q, last, idx_clamp;
	logic [CW-1:0]        px_q, py_q;
	logic [LOOK_BITS-1:0] look_q;
	logic [LSQ_W-1:0]     look_sq_q;
	logic [2*CW-1:0]      rdata;
	logic [CW-1:0]        rx, ry;
	logic [CW:0]          dxw, dyw;
	logic [CW-1:0]        dx_abs, dy_abs, dx_q, dy_q;
	logic [2*CW-1:0]      sqx_q, sqy_q;
	logic [DW-1:0]        dist_sum, look_ext;
	logic                 near;
	logic                 out_valid_q;
	logic [CW-1:0]        goal_x_q, goal_y_q;
	logic [SLOT_BITS-1:0] goal_slot_q;
	logic [SLOT_BITS+IW-1:0] slot_ext;

	// Path bookkeeping.
	assign full     = (fill_q == LW'(MAX_WAYPOINTS));
	assign fill_nxt = full ? fill_q : fill_q + LW'(1);
	assign len_m1   = len_q - LW'(1);
	assign last     = len_m1[IW-1:0];
	assign idx_clamp = (idx_q > last) ? last : idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q  <= '0;
		end else if (cmd.load) begin
			if (path_last) begin
				len_q  <= fill_nxt;
				fill_q <= '0;
			end else begin
				fill_q <= fill_nxt;
				// A new load drops the old path.
				if (fill_q == '0) begin
					len_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.start) begin
			idx_q <= idx_clamp;
		end else if (cmd.step) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	// Lookahead register and its square.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_q    <= LOOK_RESET;
			look_sq_q <= LOOK_SQ_RESET;
		end else begin
			if (cfg_valid) begin
				look_q <= cfg_data;
			end
			look_sq_q <= LSQ_W'(look_q) * LSQ_W'(look_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			px_q <= pos_x;
			py_q <= pos_y;
		end
	end

	lags_wpmem #(
		.DEPTH (MAX_WAYPOINTS),
		.WIDTH (2 * CW)
	) u_wpmem (
		.clk   (clk),
		.we    (cmd.load && !full),
		.waddr (fill_q[IW-1:0]),
		.wdata ({pos_x, pos_y}),
		.re    (cmd.rd),
		.raddr (idx_q),
		.rdata (rdata)
	);

	assign rx = rdata[2*CW-1:CW];
	assign ry = rdata[CW-1:0];

	// Absolute differences; the magnitude always fits in CW bits.
	assign dxw    = {rx[CW-1], rx} - {px_q[CW-1], px_q};
	assign dyw    = {ry[CW-1], ry} - {py_q[CW-1], py_q};
	assign dx_abs = dxw[CW] ? CW'(~dxw + (CW+1)'(1)) : dxw[CW-1:0];
	assign dy_abs = dyw[CW] ? CW'(~dyw + (CW+1)'(1)) : dyw[CW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			dx_q <= dx_abs;
			dy_q <= dy_abs;
		end
		if (cmd.mul) begin
			sqx_q <= (2*CW)'(dx_q) * (2*CW)'(dx_q);
			sqy_q <= (2*CW)'(dy_q) * (2*CW)'(dy_q);
		end
	end

	// The full-width sum never wraps, so comparing it directly matches a saturated sum.
	assign dist_sum = DW'(sqx_q) + DW'(sqy_q);
	assign look_ext = DW'(look_sq_q);
	assign near     = (dist_sum < look_ext);

	assign sts.path_empty = (len_q == '0);
	assign sts.more       = near && (idx_q < last);
	assign sts.out_busy   = out_valid_q && out_stall;

	// Output register.
	assign slot_ext = {{SLOT_BITS{1'b0}}, idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			goal_x_q    <= rx;
			goal_y_q    <= ry;
			goal_slot_q <= slot_ext[SLOT_BITS-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign goal_x    = goal_x_q;
	assign goal_y    = goal_y_q;
	assign goal_slot = goal_slot_q;

endmodule

FILE: hw/rtl/lookahead_goal_selector.sv
// Operation: a waypoint load is written from the idle state; a pose visits k >= 1
// waypoints, each through states RD, DIFF, MUL and CMP (memory read, difference,
// square, sum and compare); its result word then goes to the output register once free.
// Flow: one item at a time; the next item is taken once the result word is committed,
// while the previous result word may still wait in the output register.
// Reset clears the path, the goal index and the output; lookahead returns to 5.0 m.
`timescale 1ns / 1ps

module lookahead_goal_selector
	import lags_pkg::*;
#(
	parameter int unsigned MAX_WAYPOINTS = 1024,
	parameter int unsigned COORD_BITS    = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [LOOK_BITS-1:0]         cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         req_type,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic                         path_last,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS-1:0] goal_x,
	output logic signed [COORD_BITS-1:0] goal_y,
	output logic [SLOT_BITS-1:0]         goal_slot
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	lags_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	lags_dp #(
		.MAX_WAYPOINTS (MAX_WAYPOINTS),
		.COORD_BITS    (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.path_last (path_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.goal_x    (goal_x),
		.goal_y    (goal_y),
		.goal_slot (goal_slot)
	);

endmodule
